### rtl/srfs_pkg.sv
// shared types, constants and helpers for the sensor response frame store
package srfs_pkg;

  // table geometry
  localparam int DEVICE_SLOTS    = 16;
  localparam int PINS_PER_DEVICE = 8;
  localparam int TABLE_DEPTH     = DEVICE_SLOTS * PINS_PER_DEVICE;
  localparam int SLOT_W          = $clog2(DEVICE_SLOTS);
  localparam int PIN_W           = $clog2(PINS_PER_DEVICE);
  localparam int ADDR_W          = SLOT_W + PIN_W;

  // memory word layouts: value or level above the time stamp
  localparam int AN_WORD_W = 16 + 32;
  localparam int DG_WORD_W = 1 + 32;

  // command codes
  localparam logic [1:0] CMD_FRAME   = 2'd0;
  localparam logic [1:0] CMD_QRY_AN  = 2'd1;
  localparam logic [1:0] CMD_QRY_DG  = 2'd2;

  // frame type bytes
  localparam logic [7:0] TYPE_ACK_ON  = 8'h10;
  localparam logic [7:0] TYPE_ACK_OFF = 8'h11;
  localparam logic [7:0] TYPE_AN_ONE  = 8'h20;
  localparam logic [7:0] TYPE_DG_ONE  = 8'h21;
  localparam logic [7:0] TYPE_AN_MULT = 8'h22;
  localparam logic [7:0] TYPE_DG_PACK = 8'h23;
  localparam logic [7:0] TYPE_ERROR   = 8'hFF;

  // result kinds
  localparam logic [2:0] KIND_IGNORED = 3'd0;
  localparam logic [2:0] KIND_ACK_ON  = 3'd1;
  localparam logic [2:0] KIND_ACK_OFF = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_ANALOG  = 3'd4;
  localparam logic [2:0] KIND_DIGITAL = 3'd5;
  localparam logic [2:0] KIND_QUERY   = 3'd6;

  // decoded operation of the captured transaction
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ACK   = 3'd1;
  localparam logic [2:0] OP_AN1   = 3'd2;
  localparam logic [2:0] OP_ANM   = 3'd3;
  localparam logic [2:0] OP_DG1   = 3'd4;
  localparam logic [2:0] OP_DG8   = 3'd5;
  localparam logic [2:0] OP_QRY   = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       qread;
    logic       step_en;
    logic [2:0] step_idx;
    logic       load_result;
  } srfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_query;
    logic       has_steps;
    logic [2:0] last_step;
  } srfs_status_t;

  // byte k of the payload, byte 0 in the top bits
  function automatic logic [7:0] pl_byte(input logic [63:0] p, input logic [2:0] k);
    logic [2:0] j;
    j = 3'd7 - k;
    pl_byte = p[{j, 3'b000} +: 8];
  endfunction

endpackage

### rtl/srfs_ram.sv
// generic single write port ram with registered read
module srfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/srfs_dp.sv
// datapath: transaction registers, decode, reading tables and result register
module srfs_dp
  import srfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  srfs_cmd_t    cmd,
  output srfs_status_t status,
  input  logic [1:0]   in_command,
  input  logic [10:0]  in_frame_id,
  input  logic [3:0]   in_length,
  input  logic [63:0]  in_payload,
  input  logic [7:0]   in_query_pin,
  input  logic [31:0]  in_now_ms,
  output logic [2:0]   out_kind,
  output logic [7:0]   out_port,
  output logic [7:0]   out_status_code,
  output logic [3:0]   out_stored_count,
  output logic         out_reading_valid,
  output logic [15:0]  out_reading_value,
  output logic [31:0]  out_reading_time
);

  // captured transaction
  logic [1:0]        cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [3:0]        len_r;
  logic [63:0]       payload_r;
  logic [7:0]        qpin_r;
  logic [31:0]       now_r;
  logic [3:0]        count_r;
  logic [3:0]        count_nxt;

  // valid bits, cleared at reset
  logic [TABLE_DEPTH-1:0] an_valid_r;
  logic [TABLE_DEPTH-1:0] dg_valid_r;

  // result register
  logic [2:0]  kind_r;
  logic [7:0]  port_r;
  logic [7:0]  stat_r;
  logic [3:0]  cnt_out_r;
  logic        rvalid_r;
  logic [15:0] rvalue_r;
  logic [31:0] rtime_r;

  logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
  logic [2:0]  op;
  logic [2:0]  last_step;

  // step write signals
  logic [7:0]        wpin;
  logic [15:0]       wvalue;
  logic              wlevel;
  logic              wcomplete;
  logic              pin_ok;
  logic              an_we;
  logic              dg_we;
  logic [ADDR_W-1:0] waddr;

  // query read signals
  logic              q_ok;
  logic [ADDR_W-1:0] raddr;
  logic              an_re;
  logic              dg_re;
  logic [AN_WORD_W-1:0] an_rdata;
  logic [DG_WORD_W-1:0] dg_rdata;

  assign b0 = pl_byte(payload_r, 3'd0);
  assign b1 = pl_byte(payload_r, 3'd1);
  assign b2 = pl_byte(payload_r, 3'd2);
  assign b3 = pl_byte(payload_r, 3'd3);
  assign b4 = pl_byte(payload_r, 3'd4);
  assign b5 = pl_byte(payload_r, 3'd5);
  assign b6 = pl_byte(payload_r, 3'd6);

  // transaction capture, length saturated to eight bytes
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_command;
      slot_r    <= in_frame_id[SLOT_W-1:0];
      len_r     <= (in_length > 4'd8) ? 4'd8 : in_length;
      payload_r <= in_payload;
      qpin_r    <= in_query_pin;
      now_r     <= in_now_ms;
    end
  end

  // operation decode
  always_comb begin
    op        = OP_NONE;
    last_step = 3'd0;
    if (cmd_r == CMD_FRAME) begin
      if (len_r >= 4'd1) begin
        unique case (b0) inside
          TYPE_ACK_ON, TYPE_ACK_OFF, TYPE_ERROR: begin
            if (len_r >= 4'd3) op = OP_ACK;
          end
          TYPE_AN_ONE: begin
            if (len_r >= 4'd5) op = OP_AN1;
          end
          TYPE_AN_MULT: begin
            op        = OP_ANM;
            last_step = 3'd1;
          end
          TYPE_DG_ONE: begin
            if (len_r >= 4'd3) op = OP_DG1;
          end
          TYPE_DG_PACK: begin
            if (len_r >= 4'd2) begin
              op        = OP_DG8;
              last_step = 3'd7;
            end
          end
          default: op = OP_NONE;
        endcase
      end
    end else if (cmd_r == CMD_QRY_AN || cmd_r == CMD_QRY_DG) begin
      op = OP_QRY;
    end
  end

  assign status.is_query  = (op == OP_QRY);
  assign status.has_steps = (op == OP_AN1) || (op == OP_ANM) || (op == OP_DG1) ||
                            (op == OP_DG8);
  assign status.last_step = last_step;

  // at most one table write per step
  always_comb begin
    wpin      = b1;
    wvalue    = {b2, b3};
    wlevel    = (b2 != 8'd0);
    wcomplete = 1'b1;
    if (op == OP_ANM) begin
      if (cmd.step_idx[0]) begin
        wpin      = b4;
        wvalue    = {b5, b6};
        wcomplete = (len_r >= 4'd7);
      end else begin
        wcomplete = (len_r >= 4'd4);
      end
    end else if (op == OP_DG8) begin
      wpin   = {5'd0, cmd.step_idx};
      wlevel = b1[cmd.step_idx];
    end
  end

  assign pin_ok = (wpin < 8'(PINS_PER_DEVICE));
  assign waddr  = {slot_r, wpin[PIN_W-1:0]};
  assign an_we  = cmd.step_en && pin_ok && wcomplete && ((op == OP_AN1) || (op == OP_ANM));
  assign dg_we  = cmd.step_en && pin_ok && ((op == OP_DG1) || (op == OP_DG8));

  // stored reading count
  always_comb begin
    count_nxt = count_r;
    if (cmd.capture) begin
      count_nxt = 4'd0;
    end else if (an_we || dg_we) begin
      count_nxt = count_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_valid_r <= '0;
      dg_valid_r <= '0;
    end else begin
      if (an_we) an_valid_r[waddr] <= 1'b1;
      if (dg_we) dg_valid_r[waddr] <= 1'b1;
    end
  end

  // query address
  assign q_ok  = (qpin_r < 8'(PINS_PER_DEVICE));
  assign raddr = {slot_r, qpin_r[PIN_W-1:0]};
  assign an_re = cmd.qread && (cmd_r == CMD_QRY_AN);
  assign dg_re = cmd.qread && (cmd_r == CMD_QRY_DG);

  srfs_ram #(
    .WIDTH (AN_WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_an_ram (
    .clk   (clk),
    .we    (an_we),
    .waddr (waddr),
    .wdata ({wvalue, now_r}),
    .re    (an_re),
    .raddr (raddr),
    .rdata (an_rdata)
  );

  srfs_ram #(
    .WIDTH (DG_WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_dg_ram (
    .clk   (clk),
    .we    (dg_we),
    .waddr (waddr),
    .wdata ({wlevel, now_r}),
    .re    (dg_re),
    .raddr (raddr),
    .rdata (dg_rdata)
  );

  // result register, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      kind_r    <= KIND_IGNORED;
      port_r    <= 8'd0;
      stat_r    <= 8'd0;
      cnt_out_r <= 4'd0;
      rvalid_r  <= 1'b0;
      rvalue_r  <= 16'd0;
      rtime_r   <= 32'd0;
      case (op) inside
        OP_ACK: begin
          kind_r <= (b0 == TYPE_ACK_ON) ? KIND_ACK_ON :
                    (b0 == TYPE_ACK_OFF) ? KIND_ACK_OFF : KIND_ERROR;
          port_r <= b1;
          stat_r <= b2;
        end
        OP_AN1, OP_ANM: begin
          kind_r    <= KIND_ANALOG;
          cnt_out_r <= count_r;
        end
        OP_DG1, OP_DG8: begin
          kind_r    <= KIND_DIGITAL;
          cnt_out_r <= count_r;
        end
        OP_QRY: begin
          kind_r <= KIND_QUERY;
          if (q_ok) begin
            if (cmd_r == CMD_QRY_AN) begin
              if (an_valid_r[raddr]) begin
                rvalid_r <= 1'b1;
                rvalue_r <= an_rdata[AN_WORD_W-1:32];
                rtime_r  <= an_rdata[31:0];
              end
            end else begin
              if (dg_valid_r[raddr]) begin
                rvalid_r <= 1'b1;
                rvalue_r <= {15'd0, dg_rdata[DG_WORD_W-1]};
                rtime_r  <= dg_rdata[31:0];
              end
            end
          end
        end
        default: kind_r <= KIND_IGNORED;
      endcase
    end
  end

  assign out_kind          = kind_r;
  assign out_port          = port_r;
  assign out_status_code   = stat_r;
  assign out_stored_count  = cnt_out_r;
  assign out_reading_valid = rvalid_r;
  assign out_reading_value = rvalue_r;
  assign out_reading_time  = rtime_r;

endmodule

### rtl/srfs_ctrl.sv
// controller: sequences capture, table writes, query read and result handoff
module srfs_ctrl
  import srfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  srfs_status_t status,
  output srfs_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DISP = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    cmd.capture     = 1'b0;
    cmd.qread       = 1'b0;
    cmd.step_en     = 1'b0;
    cmd.step_idx    = step_r;
    cmd.load_result = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        step_nxt = 3'd0;
        if (status.is_query) begin
          cmd.qread = 1'b1;
          state_nxt = ST_DONE;
        end else if (status.has_steps) begin
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_STEP: begin
        cmd.step_en = 1'b1;
        if (step_r == status.last_step) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result handoff flag
  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // write steps never run past the last one of the operation
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (step_r <= status.last_step))
    else $error("step index beyond last step");

  // an accepted transaction always goes to dispatch
  a_capture_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DISP))
    else $error("accepted transaction not dispatched");

  // a loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |=> (out_valid && state_r == ST_IDLE))
    else $error("loaded result not presented");

  // a query read is followed by the handoff state
  a_qread_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.qread |=> (state_r == ST_DONE))
    else $error("query read not followed by handoff");
`endif

endmodule

### rtl/sensor_response_frame_store_core.sv
// top level of the sensor response frame store
// Takes one transaction at a time: a received frame, or a query of the analog or
// digital reading tables (16 device slots by 8 pins, slot = frame id mod 16).
// A transaction passes from capture through dispatch and its table write steps (1 for
// a single analog or digital reading, 2 for a multi analog frame, 8 for a packed
// digital frame) to the handoff state, which loads its result into the output
// register, and no new transaction is accepted before that load. The write steps
// share the one write port of each table memory. The next transaction is accepted
// while the previous result still waits in the output register; its own result
// then waits in the controller until the output register frees up, and the input
// stalls meanwhile. Reading tables come up empty after reset with no clearing pass.
module sensor_response_frame_store_core
  import srfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_payload,
  input  logic [7:0]  in_query_pin,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_port,
  output logic [7:0]  out_status_code,
  output logic [3:0]  out_stored_count,
  output logic        out_reading_valid,
  output logic [15:0] out_reading_value,
  output logic [31:0] out_reading_time
);

  srfs_cmd_t    cmd;
  srfs_status_t status;

  // sequencing
  srfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // tables and result
  srfs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_command),
    .in_frame_id       (in_frame_id),
    .in_length         (in_length),
    .in_payload        (in_payload),
    .in_query_pin      (in_query_pin),
    .in_now_ms         (in_now_ms),
    .out_kind          (out_kind),
    .out_port          (out_port),
    .out_status_code   (out_status_code),
    .out_stored_count  (out_stored_count),
    .out_reading_valid (out_reading_valid),
    .out_reading_value (out_reading_value),
    .out_reading_time  (out_reading_time)
  );

endmodule
